>>> src/combined_tausworthe_rng_bounded_macros.svh
// Assertion macros shared by the bounded Tausworthe generator RTL.
`ifndef COMBINED_TAUSWORTHE_RNG_BOUNDED_MACROS_SVH
`define COMBINED_TAUSWORTHE_RNG_BOUNDED_MACROS_SVH
`ifndef SYNTHESIS
`define CTRB_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define CTRB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define CTRB_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define CTRB_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> src/ctrb_pkg.sv
// Shared types, constants and the component step function.
`default_nettype none
package ctrb_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned QueueDepth = 2;
   localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);
   localparam int unsigned QueueCntWidth = $clog2(QueueDepth + 1);

   localparam logic [WordWidth-1:0] Seed  = 32'd12345;
   localparam logic [WordWidth-1:0] MaskA = 32'hFFFF_FFFE;
   localparam logic [WordWidth-1:0] MaskB = 32'hFFFF_FFF8;
   localparam logic [WordWidth-1:0] MaskC = 32'hFFFF_FFF0;
   localparam logic [WordWidth-1:0] MaskD = 32'hFFFF_FF80;

   typedef struct packed {
      logic [WordWidth-1:0] word;
      logic [WordWidth-1:0] limit;
   } queue_entry_type;

   typedef struct packed {
      logic not_empty;
      logic not_full;
   } queue_stat_type;

   typedef struct packed {
      logic busy;
   } back_stat_type;

   function automatic logic [WordWidth-1:0] taus_step(
      input logic [WordWidth-1:0] z,
      input int unsigned s1,
      input int unsigned s2,
      input int unsigned s3,
      input logic [WordWidth-1:0] mask
   );
      logic [WordWidth-1:0] fb;
      fb = ((z << s1) ^ z) >> s2;
      return ((z & mask) << s3) ^ fb;
   endfunction

endpackage
`default_nettype wire

>>> src/ctrb_queue.sv
// Two-entry queue between the generator front end and the modulo back end.
`default_nettype none
module ctrb_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire ctrb_pkg::queue_entry_type push_data,
   input  wire logic                     pop,
   output ctrb_pkg::queue_entry_type     pop_data,
   output ctrb_pkg::queue_stat_type      stat
);
   import ctrb_pkg::*;

   queue_entry_type mem_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCntWidth-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data       = mem_ff[rd_ptr_ff];
   assign stat.not_empty = (count_ff != '0);
   assign stat.not_full  = (count_ff != QueueCntWidth'(QueueDepth));

endmodule
`default_nettype wire

>>> src/ctrb_gen.sv
// Front end: accepts requests, steps the four components, emits the combined word.
`default_nettype none
module ctrb_gen (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [31:0]              req_limit,
   input  wire ctrb_pkg::queue_stat_type q_stat,
   output logic                          push,
   output ctrb_pkg::queue_entry_type     push_data
);
   import ctrb_pkg::*;

   logic [WordWidth-1:0] comp_a_ff, comp_a_in;
   logic [WordWidth-1:0] comp_b_ff, comp_b_in;
   logic [WordWidth-1:0] comp_c_ff, comp_c_in;
   logic [WordWidth-1:0] comp_d_ff, comp_d_in;

   always_comb begin
      comp_a_in = taus_step(comp_a_ff, 6, 13, 18, MaskA);
      comp_b_in = taus_step(comp_b_ff, 2, 27, 2, MaskB);
      comp_c_in = taus_step(comp_c_ff, 13, 21, 7, MaskC);
      comp_d_in = taus_step(comp_d_ff, 3, 12, 13, MaskD);
   end

   assign req_ready       = q_stat.not_full;
   assign push            = req_valid && req_ready;
   assign push_data.word  = comp_a_in ^ comp_b_in ^ comp_c_in ^ comp_d_in;
   assign push_data.limit = req_limit;

   always_ff @(posedge clock) begin
      if (reset) begin
         comp_a_ff <= Seed;
         comp_b_ff <= Seed;
         comp_c_ff <= Seed;
         comp_d_ff <= Seed;
      end else if (push) begin
         comp_a_ff <= comp_a_in;
         comp_b_ff <= comp_b_in;
         comp_c_ff <= comp_c_in;
         comp_d_ff <= comp_d_in;
      end
   end

endmodule
`default_nettype wire

>>> src/ctrb_mod.sv
// Back end: restoring modulo, one dividend bit per cycle, with an output register.
`default_nettype none
module ctrb_mod (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire ctrb_pkg::queue_stat_type q_stat,
   input  wire ctrb_pkg::queue_entry_type pop_data,
   output logic                          pop,
   output ctrb_pkg::back_stat_type       stat,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [31:0]                   rsp_value
);
   import ctrb_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_LOAD
   } state_type;

   localparam int unsigned StepWidth = $clog2(WordWidth);

   state_type            state_ff;
   logic [WordWidth:0]   rem_ff;
   logic [WordWidth-1:0] dvd_ff;
   logic [WordWidth-1:0] lim_ff;
   logic [StepWidth-1:0] step_ff;
   logic                 out_valid_ff;
   logic [WordWidth-1:0] out_value_ff;

   logic [WordWidth:0]   rem_sh;
   logic [WordWidth:0]   rem_in;
   logic                 out_free;
   logic                 load_out;

   assign pop      = (state_ff == ST_IDLE) && q_stat.not_empty;
   assign out_free = !out_valid_ff || rsp_ready;
   assign load_out = (state_ff == ST_LOAD) && out_free;

   always_comb begin
      rem_sh = {rem_ff[WordWidth-1:0], dvd_ff[WordWidth-1]};
      if (rem_sh >= {1'b0, lim_ff}) begin
         rem_in = rem_sh - {1'b0, lim_ff};
      end else begin
         rem_in = rem_sh;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  lim_ff  <= pop_data.limit;
                  dvd_ff  <= pop_data.word;
                  step_ff <= '0;
                  if (pop_data.limit == '0) begin
                     // zero limit passes the raw word through
                     rem_ff   <= {1'b0, pop_data.word};
                     state_ff <= ST_LOAD;
                  end else begin
                     rem_ff   <= '0;
                     state_ff <= ST_RUN;
                  end
               end
            end
            ST_RUN: begin
               rem_ff  <= rem_in;
               dvd_ff  <= dvd_ff << 1;
               step_ff <= step_ff + 1'b1;
               if (step_ff == StepWidth'(WordWidth - 1)) begin
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               if (out_free) begin
                  out_value_ff <= rem_ff[WordWidth-1:0];
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign stat.busy = (state_ff != ST_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_value = out_value_ff;

endmodule
`default_nettype wire

>>> src/combined_tausworthe_rng_bounded.sv
// A request goes through the queue, 32 bit-serial modulo steps and the output load.
// The bit-serial modulo unit takes one request at a time and pops the next when idle.
// A zero limit skips the modulo steps and passes the raw word to the output load.
// The front end takes up to two requests ahead into its queue while a result waits.
// Synchronous active-high reset seeds all four components with 12345, empties the
// queue and drops any pending result.
`default_nettype none
`include "combined_tausworthe_rng_bounded_macros.svh"
module combined_tausworthe_rng_bounded (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_limit,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_value
);
   import ctrb_pkg::*;

   queue_stat_type  q_stat;
   queue_entry_type push_data;
   queue_entry_type pop_data;
   back_stat_type   b_stat;
   logic            push;
   logic            pop;

   ctrb_gen u_gen (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_limit (req_limit),
      .q_stat    (q_stat),
      .push      (push),
      .push_data (push_data)
   );

   ctrb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .stat      (q_stat)
   );

   ctrb_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .pop_data  (pop_data),
      .pop       (pop),
      .stat      (b_stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_value (rsp_value)
   );

   `CTRB_ASSERT_NEXT(a_push_fills, clock, reset, push && !pop, q_stat.not_empty)
   `CTRB_ASSERT_NEXT(a_pop_starts, clock, reset, pop, b_stat.busy)
   `CTRB_ASSERT_IMPLY(a_rsp_from_back, clock, reset, $rose(rsp_valid), $past(b_stat.busy))

endmodule
`default_nettype wire
